FILE: hw/rtl/ncdf_pkg.sv
// ----------------------------------------------------------------------------
// ncdf_pkg
// Shared constants and types for the inverse normal CDF pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ncdf_pkg;

   localparam int PROB_BITS_DEF     = 32;
   localparam int OUT_FRAC_BITS_DEF = 28;

   localparam int QF      = 28;
   localparam int LOG_F   = 30;
   localparam int MANT_W  = 31;
   localparam int RAD_W   = 64;
   localparam int ROOT_W  = 32;
   localparam int SREM_W  = 36;
   localparam int POLY_W  = 30;
   localparam int NUM_W   = 36;
   localparam int DEN_W   = 36;
   localparam int QUO_W   = 36;
   localparam int Z_W     = 38;

   localparam logic [31:0] KC0 = 32'(((64'd2515517 << 28) + 64'd500000) / 64'd1000000);
   localparam logic [31:0] KC1 = 32'(((64'd802853 << 28) + 64'd500000) / 64'd1000000);
   localparam logic [31:0] KC2 = 32'(((64'd10328 << 28) + 64'd500000) / 64'd1000000);
   localparam logic [31:0] KD0 = 32'(((64'd1432788 << 28) + 64'd500000) / 64'd1000000);
   localparam logic [31:0] KD1 = 32'(((64'd189269 << 28) + 64'd500000) / 64'd1000000);
   localparam logic [31:0] KD2 = 32'(((64'd1308 << 28) + 64'd500000) / 64'd1000000);
   localparam logic [31:0] QONE = 32'h1000_0000;
   localparam logic [31:0] TWO_LN2_Q31 = 32'hB172_17F8;

   typedef struct packed {
      logic valid;
      logic advance;
   } pipe_ctl_type;

   typedef struct packed {
      logic lower;
      logic invalid;
   } flag_type;

   typedef struct packed {
      logic              lower;
      logic              invalid;
      logic [ROOT_W-1:0] t;
   } div_side_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ncdf_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// ncdf_sqrt_pipe
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ncdf_sqrt_pipe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ncdf_pkg::pipe_ctl_type        ctl,
   input  wire logic [ncdf_pkg::RAD_W-1:0]    rad_in,
   input  wire ncdf_pkg::flag_type            flags_in,
   output logic                               valid_out,
   output logic [ncdf_pkg::ROOT_W-1:0]        root_out,
   output ncdf_pkg::flag_type                 flags_out
);

   localparam int N = ncdf_pkg::ROOT_W;

   logic                          valid_ff [0:N-1];
   logic [ncdf_pkg::SREM_W-1:0]   rem_ff   [0:N-1];
   logic [ncdf_pkg::ROOT_W-1:0]   root_ff  [0:N-1];
   logic [ncdf_pkg::RAD_W-1:0]    rad_ff   [0:N-1];
   ncdf_pkg::flag_type            flags_ff [0:N-1];

   genvar j;
   generate
      for (j = 0; j < N; j++) begin : g_step
         logic                        v_src;
         logic [ncdf_pkg::SREM_W-1:0] rem_src;
         logic [ncdf_pkg::ROOT_W-1:0] root_src;
         logic [ncdf_pkg::RAD_W-1:0]  rad_src;
         ncdf_pkg::flag_type          fl_src;
         logic [ncdf_pkg::SREM_W-1:0] rsh;
         logic [ncdf_pkg::SREM_W-1:0] trial;
         logic                        ge;

         if (j == 0) begin : g_first
            assign v_src    = ctl.valid;
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = rad_in;
            assign fl_src   = flags_in;
         end else begin : g_next
            assign v_src    = valid_ff[j-1];
            assign rem_src  = rem_ff[j-1];
            assign root_src = root_ff[j-1];
            assign rad_src  = rad_ff[j-1];
            assign fl_src   = flags_ff[j-1];
         end

         assign rsh   = {rem_src[ncdf_pkg::SREM_W-3:0], rad_src[ncdf_pkg::RAD_W-1 -: 2]};
         assign trial = {2'b00, root_src, 2'b01};
         assign ge    = (rsh >= trial);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j] <= 1'b0;
            end else if (ctl.advance) begin
               valid_ff[j] <= v_src;
            end
            if (ctl.advance) begin
               rem_ff[j]   <= ge ? (rsh - trial) : rsh;
               root_ff[j]  <= {root_src[ncdf_pkg::ROOT_W-2:0], ge};
               rad_ff[j]   <= rad_src << 2;
               flags_ff[j] <= fl_src;
            end
         end
      end
   endgenerate

   assign valid_out = valid_ff[N-1];
   assign root_out  = root_ff[N-1];
   assign flags_out = flags_ff[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/ncdf_div_pipe.sv
// ----------------------------------------------------------------------------
// ncdf_div_pipe
// Pipelined restoring divider for the rational term, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ncdf_div_pipe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ncdf_pkg::pipe_ctl_type        ctl,
   input  wire logic [ncdf_pkg::NUM_W-1:0]    num_in,
   input  wire logic [ncdf_pkg::DEN_W-1:0]    den_in,
   input  wire ncdf_pkg::div_side_type        side_in,
   output logic                               valid_out,
   output logic [ncdf_pkg::QUO_W-1:0]         quo_out,
   output ncdf_pkg::div_side_type             side_out
);

   localparam int N    = ncdf_pkg::QUO_W;
   localparam int RW   = ncdf_pkg::DEN_W + 1;
   localparam int HI_W = ncdf_pkg::NUM_W - (N - ncdf_pkg::QF);

   logic                          valid_ff [0:N-1];
   logic [RW-1:0]                 rem_ff   [0:N-1];
   logic [N-1:0]                  quo_ff   [0:N-1];
   logic [N-1:0]                  low_ff   [0:N-1];
   logic [ncdf_pkg::DEN_W-1:0]    den_ff   [0:N-1];
   ncdf_pkg::div_side_type        side_ff  [0:N-1];

   genvar j;
   generate
      for (j = 0; j < N; j++) begin : g_step
         logic                       v_src;
         logic [RW-1:0]              rem_src;
         logic [N-1:0]               quo_src;
         logic [N-1:0]               low_src;
         logic [ncdf_pkg::DEN_W-1:0] den_src;
         ncdf_pkg::div_side_type     sd_src;
         logic [RW-1:0]              rsh;
         logic                       ge;

         if (j == 0) begin : g_first
            assign v_src   = ctl.valid;
            assign rem_src = RW'(num_in[ncdf_pkg::NUM_W-1 -: HI_W]);
            assign quo_src = '0;
            assign low_src = {num_in[N-ncdf_pkg::QF-1:0], {ncdf_pkg::QF{1'b0}}};
            assign den_src = den_in;
            assign sd_src  = side_in;
         end else begin : g_next
            assign v_src   = valid_ff[j-1];
            assign rem_src = rem_ff[j-1];
            assign quo_src = quo_ff[j-1];
            assign low_src = low_ff[j-1];
            assign den_src = den_ff[j-1];
            assign sd_src  = side_ff[j-1];
         end

         assign rsh = {rem_src[RW-2:0], low_src[N-1]};
         assign ge  = (rsh >= {1'b0, den_src});

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j] <= 1'b0;
            end else if (ctl.advance) begin
               valid_ff[j] <= v_src;
            end
            if (ctl.advance) begin
               rem_ff[j]  <= ge ? (rsh - {1'b0, den_src}) : rsh;
               quo_ff[j]  <= {quo_src[N-2:0], ge};
               low_ff[j]  <= low_src << 1;
               den_ff[j]  <= den_src;
               side_ff[j] <= sd_src;
            end
         end
      end
   endgenerate

   assign valid_out = valid_ff[N-1];
   assign quo_out   = quo_ff[N-1];
   assign side_out  = side_ff[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/inverse_normal_cdf_unit.sv
// ----------------------------------------------------------------------------
// inverse_normal_cdf_unit
// Rational approximation of the standard normal quantile, fully pipelined.
// ----------------------------------------------------------------------------
// Stages: 30 log2 squaring stages, 32 square root stages, 36 divider stages
//   and 8 others lie between an accepted item and its result.
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Reset: clears the valid bit of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module inverse_normal_cdf_unit #(
   parameter int PROB_BITS     = ncdf_pkg::PROB_BITS_DEF,
   parameter int OUT_FRAC_BITS = ncdf_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [31:0]        req_prob_fraction,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_quantile,
   output logic                    rsp_invalid
);

   localparam int KW    = $clog2(PROB_BITS);
   localparam int LHW   = $clog2(PROB_BITS + 1);
   localparam int XW    = LHW + 32;
   localparam int NSQ   = ncdf_pkg::LOG_F;
   localparam int SHIFT = OUT_FRAC_BITS - ncdf_pkg::QF;
   localparam int LS    = (SHIFT > 0) ? SHIFT : 0;
   localparam int RS    = (SHIFT < 0) ? -SHIFT : 1;
   localparam int MW    = ncdf_pkg::Z_W + LS;

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: fold probability
   logic [PROB_BITS-1:0] p_w;
   logic                 s1_valid_ff;
   logic [PROB_BITS-1:0] s1_q_ff;
   ncdf_pkg::flag_type   s1_flags_ff;

   assign p_w = PROB_BITS'(req_prob_fraction);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_q_ff             <= p_w[PROB_BITS-1] ? (~p_w + 1'b1) : p_w;
         s1_flags_ff.lower   <= !p_w[PROB_BITS-1];
         s1_flags_ff.invalid <= (p_w == '0);
      end
   end

   // stage 2: leading one and normalise
   logic [KW-1:0]           k_w;
   logic [PROB_BITS+29:0]   wide_w;

   always_comb begin
      k_w = '0;
      for (int i = 0; i < PROB_BITS; i++) begin
         if (s1_q_ff[i]) k_w = KW'(i);
      end
   end

   assign wide_w = {s1_q_ff, 30'b0} >> k_w;

   logic                          lv_ff    [0:NSQ];
   logic [ncdf_pkg::MANT_W-1:0]   m_ff     [0:NSQ];
   logic [ncdf_pkg::LOG_F-1:0]    f_ff     [0:NSQ];
   logic [KW-1:0]                 k_ff     [0:NSQ];
   ncdf_pkg::flag_type            lflg_ff  [0:NSQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff[0] <= 1'b0;
      end else if (advance) begin
         lv_ff[0] <= s1_valid_ff;
      end
      if (advance) begin
         m_ff[0]    <= wide_w[ncdf_pkg::MANT_W-1:0];
         f_ff[0]    <= '0;
         k_ff[0]    <= k_w;
         lflg_ff[0] <= s1_flags_ff;
      end
   end

   // log2 fraction by repeated squaring
   genvar j;
   generate
      for (j = 0; j < NSQ; j++) begin : g_sq
         logic [2*ncdf_pkg::MANT_W-1:0] sq;
         logic [ncdf_pkg::MANT_W:0]     mm;

         assign sq = m_ff[j] * m_ff[j];
         assign mm = sq[2*ncdf_pkg::MANT_W-1 -: ncdf_pkg::MANT_W+1];

         always_ff @(posedge clock) begin
            if (reset) begin
               lv_ff[j+1] <= 1'b0;
            end else if (advance) begin
               lv_ff[j+1] <= lv_ff[j];
            end
            if (advance) begin
               m_ff[j+1]    <= mm[ncdf_pkg::MANT_W] ? mm[ncdf_pkg::MANT_W:1]
                                                    : mm[ncdf_pkg::MANT_W-1:0];
               f_ff[j+1]    <= f_ff[j] |
                               (mm[ncdf_pkg::MANT_W] ? (ncdf_pkg::LOG_F'(1) << (NSQ-1-j))
                                                     : '0);
               k_ff[j+1]    <= k_ff[j];
               lflg_ff[j+1] <= lflg_ff[j];
            end
         end
      end
   endgenerate

   // scale by 2 ln 2
   logic [LHW-1:0]             lbase_w;
   logic [LHW-1:0]             lhi_w;
   logic [ncdf_pkg::LOG_F-1:0] llo_w;
   logic [XW-1:0]              x_w;
   logic                       xv_ff;
   logic [XW-1:0]              x_ff;
   ncdf_pkg::flag_type         xflg_ff;

   assign lbase_w = LHW'(PROB_BITS) - LHW'(k_ff[NSQ]);
   assign lhi_w   = (f_ff[NSQ] == '0) ? lbase_w : (lbase_w - 1'b1);
   assign llo_w   = (f_ff[NSQ] == '0) ? '0
                  : ncdf_pkg::LOG_F'(31'h4000_0000 - 31'(f_ff[NSQ]));
   assign x_w     = XW'((64'(lhi_w) * 64'(ncdf_pkg::TWO_LN2_Q31)) >> 1)
                  + XW'((64'(llo_w) * 64'(ncdf_pkg::TWO_LN2_Q31)) >> 31);

   always_ff @(posedge clock) begin
      if (reset) begin
         xv_ff <= 1'b0;
      end else if (advance) begin
         xv_ff <= lv_ff[NSQ];
      end
      if (advance) begin
         x_ff    <= x_w;
         xflg_ff <= lflg_ff[NSQ];
      end
   end

   // square root
   ncdf_pkg::pipe_ctl_type          sq_ctl;
   logic                            tv_w;
   logic [ncdf_pkg::ROOT_W-1:0]     t_w;
   ncdf_pkg::flag_type              tflg_w;

   assign sq_ctl.valid   = xv_ff;
   assign sq_ctl.advance = advance;

   ncdf_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sq_ctl),
      .rad_in    (ncdf_pkg::RAD_W'(x_ff) << 26),
      .flags_in  (xflg_ff),
      .valid_out (tv_w),
      .root_out  (t_w),
      .flags_out (tflg_w)
   );

   // polynomials, Horner form
   logic                        pa_valid_ff, pb_valid_ff, pc_valid_ff;
   logic [ncdf_pkg::POLY_W-1:0] pa_a_ff, pa_b_ff;
   logic [ncdf_pkg::NUM_W-1:0]  pb_n_ff, pc_n_ff;
   logic [ncdf_pkg::DEN_W-1:0]  pb_b_ff, pc_d_ff;
   ncdf_pkg::div_side_type      pa_side_ff, pb_side_ff, pc_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff <= 1'b0;
         pb_valid_ff <= 1'b0;
         pc_valid_ff <= 1'b0;
      end else if (advance) begin
         pa_valid_ff <= tv_w;
         pb_valid_ff <= pa_valid_ff;
         pc_valid_ff <= pb_valid_ff;
      end
      if (advance) begin
         pa_a_ff    <= ncdf_pkg::POLY_W'(((64'(ncdf_pkg::KC2) * 64'(t_w)) >> 28)
                                         + 64'(ncdf_pkg::KC1));
         pa_b_ff    <= ncdf_pkg::POLY_W'(((64'(ncdf_pkg::KD2) * 64'(t_w)) >> 28)
                                         + 64'(ncdf_pkg::KD1));
         pa_side_ff <= '{lower: tflg_w.lower, invalid: tflg_w.invalid, t: t_w};

         pb_n_ff    <= ncdf_pkg::NUM_W'(((64'(pa_a_ff) * 64'(pa_side_ff.t)) >> 28)
                                        + 64'(ncdf_pkg::KC0));
         pb_b_ff    <= ncdf_pkg::DEN_W'(((64'(pa_b_ff) * 64'(pa_side_ff.t)) >> 28)
                                        + 64'(ncdf_pkg::KD0));
         pb_side_ff <= pa_side_ff;

         pc_n_ff    <= pb_n_ff;
         pc_d_ff    <= ncdf_pkg::DEN_W'(((72'(pb_b_ff) * 72'(pb_side_ff.t)) >> 28)
                                        + 72'(ncdf_pkg::QONE));
         pc_side_ff <= pb_side_ff;
      end
   end

   // rational term quotient
   ncdf_pkg::pipe_ctl_type        dv_ctl;
   logic                          rv_w;
   logic [ncdf_pkg::QUO_W-1:0]    r_w;
   ncdf_pkg::div_side_type        rside_w;

   assign dv_ctl.valid   = pc_valid_ff;
   assign dv_ctl.advance = advance;

   ncdf_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dv_ctl),
      .num_in    (pc_n_ff),
      .den_in    (pc_d_ff),
      .side_in   (pc_side_ff),
      .valid_out (rv_w),
      .quo_out   (r_w),
      .side_out  (rside_w)
   );

   // difference, sign and magnitude
   logic [ncdf_pkg::Z_W-1:0] z_w;
   logic                     zv_ff;
   logic [ncdf_pkg::Z_W-1:0] mag_ff;
   logic                     neg_ff;
   logic                     zinv_ff;

   assign z_w = ncdf_pkg::Z_W'(rside_w.t) - ncdf_pkg::Z_W'(r_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         zv_ff <= 1'b0;
      end else if (advance) begin
         zv_ff <= rv_w;
      end
      if (advance) begin
         mag_ff  <= z_w[ncdf_pkg::Z_W-1] ? (~z_w + 1'b1) : z_w;
         neg_ff  <= rside_w.lower ^ z_w[ncdf_pkg::Z_W-1];
         zinv_ff <= rside_w.invalid;
      end
   end

   // scale, round and saturate
   logic [MW-1:0] ext_w;
   logic [MW-1:0] scaled_w;
   logic [31:0]   sat_w;
   logic [31:0]   out_w;

   assign ext_w = MW'(mag_ff);

   always_comb begin
      if (SHIFT < 0) begin
         scaled_w = (ext_w + (MW'(1) << (RS - 1))) >> RS;
      end else begin
         scaled_w = ext_w << LS;
      end
      if (neg_ff) begin
         sat_w = (scaled_w > MW'(64'h8000_0000)) ? 32'h8000_0000 : scaled_w[31:0];
         out_w = ~sat_w + 1'b1;
      end else begin
         sat_w = (scaled_w > MW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : scaled_w[31:0];
         out_w = sat_w;
      end
      if (zinv_ff) begin
         out_w = '0;
      end
   end

   logic        rsp_valid_ff;
   logic [31:0] rsp_quantile_ff;
   logic        rsp_invalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= zv_ff;
      end
      if (advance) begin
         rsp_quantile_ff <= out_w;
         rsp_invalid_ff  <= zinv_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_quantile = $signed(rsp_quantile_ff);
   assign rsp_invalid  = rsp_invalid_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_quantile == 32'sd0))
      else $error("invalid item with non-zero quantile");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> ($stable(s1_valid_ff) && $stable(zv_ff)))
      else $error("pipeline moved during stall");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inverse normal CDF unit. Each accepted item
// has its quantile and invalid flag predicted in fixed point; results are
// compared in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   localparam int PB  = ncdf_pkg::PROB_BITS_DEF;
   localparam int OFB = ncdf_pkg::OUT_FRAC_BITS_DEF;
   localparam int QFB = ncdf_pkg::QF;

   typedef struct {
      logic signed [31:0] quantile;
      logic               invalid;
   } quantile_type;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] neg_log2(input logic [63:0] q);
      int          k;
      logic [63:0] m;
      logic [63:0] f;
      k = 0;
      f = 0;
      while (k < 63 && (q >> (k + 1)) != 0) k++;
      if (k >= 30) m = q >> (k - 30);
      else m = q << (30 - k);
      for (int i = 29; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            f[i] = 1'b1;
         end
      end
      return ((64'(PB) - 64'(k)) << 30) - f;
   endfunction

   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> QFB;
   endfunction

   function automatic quantile_type predict_quantile(input logic [31:0] pf);
      quantile_type r;
      logic [63:0] pmask, p, q, lq, lhi, llo, x, t, n, d, quo, mag;
      logic signed [63:0] z;
      logic        lower, neg;
      int          s;
      pmask = ((64'd1 << (PB - 1)) << 1) - 1;
      p = 64'(pf) & pmask;
      r.quantile = 0;
      r.invalid = 1'b1;
      if (p == 0) return r;
      lower = p < (64'd1 << (PB - 1));
      q = lower ? p : (pmask - p) + 1;
      lq = neg_log2(q);
      lhi = lq >> 30;
      llo = lq & ((64'd1 << 30) - 1);
      x = ((lhi * 64'(ncdf_pkg::TWO_LN2_Q31)) >> 1)
        + ((llo * 64'(ncdf_pkg::TWO_LN2_Q31)) >> 31);
      t = int_sqrt(x << 26);
      n = qmul(qmul(64'(ncdf_pkg::KC2), t) + 64'(ncdf_pkg::KC1), t) + 64'(ncdf_pkg::KC0);
      d = qmul(qmul(qmul(64'(ncdf_pkg::KD2), t) + 64'(ncdf_pkg::KD1), t)
               + 64'(ncdf_pkg::KD0), t) + 64'(ncdf_pkg::QONE);
      quo = (n << QFB) / d;
      z = $signed(t) - $signed(quo);
      neg = lower != (z < 0);
      mag = (z < 0) ? 64'(-z) : 64'(z);
      s = OFB - QFB;
      if (s > 0) mag = mag << s;
      else if (s < 0) mag = (mag + (64'd1 << (-s - 1))) >> (-s);
      if (neg) begin
         if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
         r.quantile = 32'((64'd1 << 32) - mag);
      end else begin
         if (mag > ((64'd1 << 31) - 1)) mag = (64'd1 << 31) - 1;
         r.quantile = 32'(mag);
      end
      r.invalid = 1'b0;
      return r;
   endfunction

   class quantile_board;
      quantile_type pending[$];
      int           errors = 0;

      function void note_prob(logic [31:0] pf);
         pending.insert(pending.size(), predict_quantile(pf));
      endfunction

      function void check_result(logic signed [31:0] qv, logic inv);
         quantile_type e;
         if (pending.size() == 0) begin
            $error("unexpected result quantile=%0d invalid=%0d", qv, inv);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (qv !== e.quantile) begin
            $error("quantile: expected %0d, actual %0d", e.quantile, qv);
            errors++;
         end
         if (inv !== e.invalid) begin
            $error("invalid: expected %0d, actual %0d", e.invalid, inv);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_prob_fraction = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_quantile;
   logic               rsp_invalid;

   int                 idle_pct = 0;
   int                 stall_pct = 0;
   quantile_board      board = new();

   inverse_normal_cdf_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_prob_fraction(req_prob_fraction),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quantile(rsp_quantile), .rsp_invalid(rsp_invalid)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_prob(req_prob_fraction);
         if (rsp_valid && rsp_ready) board.check_result(rsp_quantile, rsp_invalid);
      end
   end

   task automatic send_prob(input logic [31:0] pf);
      logic done;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_prob_fraction <= pf;
      do begin
         @(negedge clock);
         done = req_ready;
         @(posedge clock);
      end while (!done);
   endtask

   function automatic logic [31:0] random_prob();
      int sel;
      int sh;
      sel = $urandom_range(9);
      sh = $urandom_range(31);
      case (sel)
         0, 1, 2, 3: return $urandom;
         4: return $urandom >> sh;
         5: return ~($urandom >> sh);
         6: return 32'h8000_0000 + 32'($urandom_range(64)) - 32'd32;
         7: return 32'd1 << sh;
         8: return 32'($urandom_range(16));
         default: return 32'hFFFF_FFFF - 32'($urandom_range(16));
      endcase
   endfunction

   initial begin
      int pcts[4][2];
      pcts = '{'{0, 0}, '{54, 0}, '{0, 54}, '{26, 26}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (pcts[i]) begin
         idle_pct = pcts[i][0];
         stall_pct = pcts[i][1];
         if (i == 0) begin
            send_prob(32'h0000_0000);
            send_prob(32'h0000_0001);
            send_prob(32'h0000_0002);
            send_prob(32'h0000_0003);
            send_prob(32'hFFFF_FFFF);
            send_prob(32'hFFFF_FFFE);
            send_prob(32'h8000_0000);
            send_prob(32'h7FFF_FFFF);
            send_prob(32'h8000_0001);
            send_prob(32'h4000_0000);
            send_prob(32'hC000_0000);
            send_prob(32'h5555_5555);
            send_prob(32'hAAAA_AAAA);
            send_prob(32'h0000_0000);
            send_prob(32'h0001_0000);
            send_prob(32'hFFFF_0000);
            send_prob(32'h0F0F_0F0F);
            send_prob(32'hF0F0_F0F0);
         end
         repeat (400) send_prob(random_prob());
      end
      req_valid <= 1'b0;
      stall_pct = 20;
      fork
         wait (board.pending.size() == 0);
         repeat (20000) @(posedge clock);
      join_any
      disable fork;
      repeat (150) @(posedge clock);
      if (board.pending.size() != 0) begin
         $error("%0d results never arrived", board.pending.size());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
